@@ sv/ftpr_pkg.sv @@
// ----------------------------------------------------------------------------
// ftpr_pkg
// Types and codes shared by the file-transfer packet receiver modules.
// ----------------------------------------------------------------------------
package ftpr_pkg;

   // Input word: one packet byte and its end-of-packet mark
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_type;

   // Result word, one per input word
   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_byte;
      logic [2:0]  packet_status;
      logic [7:0]  seq_number;
      logic [15:0] payload_length;
      logic [63:0] file_size;
      logic        name_present;
      logic [63:0] expected_total;
      logic [63:0] received_total;
      logic        session_open;
   } rsp_type;

   // Configuration registers
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_CODE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CODE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CODE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_TAG   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_TAG   = 3'd4;

   typedef struct packed {
      logic [7:0] data_code;
      logic [7:0] start_code;
      logic [7:0] end_code;
      logic [7:0] size_tag;
      logic [7:0] name_tag;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      data_code:  8'd1,
      start_code: 8'd2,
      end_code:   8'd3,
      size_tag:   8'd0,
      name_tag:   8'd1
   };

   // Packet kind, decided by the first byte
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   // Classified word passed from front to back
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
      logic [1:0] lead_kind;
   } word_type;

   localparam int QUEUE_DEPTH = 2;

   // Streamed byte kind
   localparam logic [1:0] OUT_NONE    = 2'd0;
   localparam logic [1:0] OUT_PAYLOAD = 2'd1;
   localparam logic [1:0] OUT_NAME    = 2'd2;

   // Packet status
   localparam logic [2:0] ST_PENDING    = 3'd0;
   localparam logic [2:0] ST_DATA_OK    = 3'd1;
   localparam logic [2:0] ST_DATA_SHORT = 3'd2;
   localparam logic [2:0] ST_NO_SESSION = 3'd3;
   localparam logic [2:0] ST_START_OK   = 3'd4;
   localparam logic [2:0] ST_START_BAD  = 3'd5;
   localparam logic [2:0] ST_END        = 3'd6;
   localparam logic [2:0] ST_UNKNOWN    = 3'd7;

endpackage

@@ sv/ftpr_front.sv @@
// ----------------------------------------------------------------------------
// ftpr_front
// Configuration registers and first-byte classification of incoming words.
// ----------------------------------------------------------------------------
module ftpr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ftpr_pkg::req_type                  req_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ftpr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                         csr_wdata,
   output ftpr_pkg::cfg_type                  cfg,
   output logic                               push_valid,
   input  logic                               push_ready,
   output ftpr_pkg::word_type                 push_word
);

   ftpr_pkg::cfg_type cfg_ff;
   ftpr_pkg::cfg_type cfg_in;
   logic [1:0]        lead_kind;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ftpr_pkg::CSR_DATA_CODE:  cfg_in.data_code  = csr_wdata;
            ftpr_pkg::CSR_START_CODE: cfg_in.start_code = csr_wdata;
            ftpr_pkg::CSR_END_CODE:   cfg_in.end_code   = csr_wdata;
            ftpr_pkg::CSR_SIZE_TAG:   cfg_in.size_tag   = csr_wdata;
            ftpr_pkg::CSR_NAME_TAG:   cfg_in.name_tag   = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ftpr_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Start code wins over data code, data over end
   always_comb begin
      if (req_payload.rx_byte == cfg_ff.start_code) begin
         lead_kind = ftpr_pkg::KIND_START;
      end else if (req_payload.rx_byte == cfg_ff.data_code) begin
         lead_kind = ftpr_pkg::KIND_DATA;
      end else if (req_payload.rx_byte == cfg_ff.end_code) begin
         lead_kind = ftpr_pkg::KIND_END;
      end else begin
         lead_kind = ftpr_pkg::KIND_OTHER;
      end
   end

   assign cfg                 = cfg_ff;
   assign push_valid          = req_valid;
   assign req_ready           = push_ready;
   assign push_word.rx_byte   = req_payload.rx_byte;
   assign push_word.last_byte = req_payload.last_byte;
   assign push_word.lead_kind = lead_kind;

endmodule

@@ sv/ftpr_queue.sv @@
// ----------------------------------------------------------------------------
// ftpr_queue
// Short word queue between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
module ftpr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  ftpr_pkg::word_type push_word,
   output logic               pop_valid,
   input  logic               pop_ready,
   output ftpr_pkg::word_type pop_word
);

   localparam int Depth  = ftpr_pkg::QUEUE_DEPTH;
   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   ftpr_pkg::word_type entries_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CountW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(Depth))
      else $error("queue count beyond depth");

endmodule

@@ sv/ftpr_back.sv @@
// ----------------------------------------------------------------------------
// ftpr_back
// Packet parser: walks data headers and control fields, keeps session
// counters and registers one result word per input word.
// ----------------------------------------------------------------------------
module ftpr_back #(
   parameter int SIZE_BYTES_MAX = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  ftpr_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  ftpr_pkg::word_type pop_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ftpr_pkg::rsp_type  rsp_payload
);

   localparam int TakenW = $clog2(SIZE_BYTES_MAX + 1);

   localparam logic [3:0] PH_FIRST   = 4'd0;
   localparam logic [3:0] PH_SEQ     = 4'd1;
   localparam logic [3:0] PH_LEN_HI  = 4'd2;
   localparam logic [3:0] PH_LEN_LO  = 4'd3;
   localparam logic [3:0] PH_PAYLOAD = 4'd4;
   localparam logic [3:0] PH_TAG     = 4'd5;
   localparam logic [3:0] PH_LEN     = 4'd6;
   localparam logic [3:0] PH_VALUE   = 4'd7;
   localparam logic [3:0] PH_SKIP    = 4'd8;

   logic [3:0]        phase_ff, phase_in;
   logic [1:0]        kind_ff, kind_in;
   logic [7:0]        field_tag_ff, field_tag_in;
   logic [7:0]        field_left_ff, field_left_in;
   logic [TakenW-1:0] taken_ff, taken_in;
   logic [63:0]       accum_ff, accum_in;
   logic              name_seen_ff, name_seen_in;
   logic              bad_field_ff, bad_field_in;
   logic [15:0]       len_ff, len_in;
   logic [15:0]       count_ff, count_in;
   logic [7:0]        seq_ff, seq_in;
   logic              session_ff, session_in;
   logic [63:0]       expected_ff, expected_in;
   logic [63:0]       received_ff, received_in;

   logic              rsp_valid_ff, rsp_valid_in;
   ftpr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              fire;
   logic [7:0]        b;
   logic              tag_is_size, tag_is_name;
   logic [1:0]        okind;
   logic [7:0]        obyte;
   logic [2:0]        status_in;
   logic              namep;

   assign fire      = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign b         = pop_word.rx_byte;

   // Size tag wins when both tags are equal
   assign tag_is_size = (field_tag_ff == cfg.size_tag);
   assign tag_is_name = !tag_is_size && (field_tag_ff == cfg.name_tag);

   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      field_tag_in  = field_tag_ff;
      field_left_in = field_left_ff;
      taken_in      = taken_ff;
      accum_in      = accum_ff;
      name_seen_in  = name_seen_ff;
      bad_field_in  = bad_field_ff;
      len_in        = len_ff;
      count_in      = count_ff;
      seq_in        = seq_ff;
      session_in    = session_ff;
      expected_in   = expected_ff;
      received_in   = received_ff;
      okind         = ftpr_pkg::OUT_NONE;
      obyte         = 8'd0;
      status_in     = ftpr_pkg::ST_PENDING;
      namep         = 1'b0;

      case (phase_ff)
         PH_FIRST: begin
            field_tag_in  = 8'd0;
            field_left_in = 8'd0;
            taken_in      = '0;
            accum_in      = 64'd0;
            name_seen_in  = 1'b0;
            bad_field_in  = 1'b0;
            len_in        = 16'd0;
            count_in      = 16'd0;
            seq_in        = 8'd0;
            kind_in       = pop_word.lead_kind;
            case (pop_word.lead_kind)
               ftpr_pkg::KIND_START: phase_in = PH_TAG;
               ftpr_pkg::KIND_DATA:  phase_in = session_ff ? PH_SEQ : PH_SKIP;
               ftpr_pkg::KIND_END:   phase_in = PH_TAG;
               default:              phase_in = PH_SKIP;
            endcase
         end
         PH_SEQ: begin
            seq_in   = b;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in   = {b, 8'd0};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in   = {len_ff[15:8], b};
            phase_in = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            // drop bytes beyond the declared length
            if (count_ff < len_ff) begin
               okind    = ftpr_pkg::OUT_PAYLOAD;
               obyte    = b;
               count_in = count_ff + 16'd1;
            end
         end
         PH_TAG: begin
            field_tag_in = b;
            phase_in     = PH_LEN;
         end
         PH_LEN: begin
            field_left_in = b;
            if (tag_is_size) begin
               accum_in = 64'd0;
               taken_in = '0;
            end else if (tag_is_name) begin
               name_seen_in = 1'b1;
            end
            phase_in = (b == 8'd0) ? PH_TAG : PH_VALUE;
         end
         PH_VALUE: begin
            if (tag_is_size) begin
               if (taken_ff < TakenW'(SIZE_BYTES_MAX)) begin
                  accum_in = {accum_ff[55:0], b};
                  taken_in = taken_ff + TakenW'(1);
               end
            end else if (tag_is_name) begin
               okind = ftpr_pkg::OUT_NAME;
               obyte = b;
            end
            field_left_in = field_left_ff - 8'd1;
            if (field_left_ff == 8'd1) begin
               phase_in = PH_TAG;
            end
         end
         default: phase_in = PH_SKIP;
      endcase

      // Close the packet on its last word
      if (pop_word.last_byte) begin
         if (kind_in == ftpr_pkg::KIND_OTHER) begin
            status_in = ftpr_pkg::ST_UNKNOWN;
         end else if (kind_in == ftpr_pkg::KIND_DATA) begin
            if (phase_in == PH_SKIP) begin
               status_in = ftpr_pkg::ST_NO_SESSION;
            end else if (phase_in == PH_PAYLOAD && count_in >= len_in) begin
               received_in = received_ff + {48'd0, len_in};
               status_in   = ftpr_pkg::ST_DATA_OK;
            end else begin
               status_in = ftpr_pkg::ST_DATA_SHORT;
            end
         end else begin
            bad_field_in = (phase_in == PH_VALUE);
            namep        = !bad_field_in && name_seen_in;
            if (kind_in == ftpr_pkg::KIND_START) begin
               if (namep) begin
                  session_in  = 1'b1;
                  expected_in = accum_in;
                  received_in = 64'd0;
                  status_in   = ftpr_pkg::ST_START_OK;
               end else begin
                  status_in = ftpr_pkg::ST_START_BAD;
               end
            end else begin
               session_in = 1'b0;
               status_in  = ftpr_pkg::ST_END;
            end
         end
         phase_in = PH_FIRST;
      end

      rsp_data_in.out_kind       = okind;
      rsp_data_in.out_byte       = obyte;
      rsp_data_in.packet_status  = status_in;
      rsp_data_in.seq_number     = seq_in;
      rsp_data_in.payload_length = len_in;
      rsp_data_in.file_size      = ((kind_in == ftpr_pkg::KIND_START ||
                                     kind_in == ftpr_pkg::KIND_END) && !bad_field_in)
                                   ? accum_in : 64'd0;
      rsp_data_in.name_present   = namep;
      rsp_data_in.expected_total = expected_in;
      rsp_data_in.received_total = received_in;
      rsp_data_in.session_open   = session_in;
   end

   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         kind_ff       <= ftpr_pkg::KIND_DATA;
         field_tag_ff  <= 8'd0;
         field_left_ff <= 8'd0;
         taken_ff      <= '0;
         accum_ff      <= 64'd0;
         name_seen_ff  <= 1'b0;
         bad_field_ff  <= 1'b0;
         len_ff        <= 16'd0;
         count_ff      <= 16'd0;
         seq_ff        <= 8'd0;
         session_ff    <= 1'b0;
         expected_ff   <= 64'd0;
         received_ff   <= 64'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff      <= phase_in;
            kind_ff       <= kind_in;
            field_tag_ff  <= field_tag_in;
            field_left_ff <= field_left_in;
            taken_ff      <= taken_in;
            accum_ff      <= accum_in;
            name_seen_ff  <= name_seen_in;
            bad_field_ff  <= bad_field_in;
            len_ff        <= len_in;
            count_ff      <= count_in;
            seq_ff        <= seq_in;
            session_ff    <= session_in;
            expected_ff   <= expected_in;
            received_ff   <= received_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_count_in_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> count_ff <= len_ff)
      else $error("payload count ran past declared length");

   a_stream_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.out_kind != ftpr_pkg::OUT_NONE |->
         rsp_data_ff.packet_status != ftpr_pkg::ST_NO_SESSION &&
         rsp_data_ff.packet_status != ftpr_pkg::ST_UNKNOWN)
      else $error("streamed byte on a refused or unknown packet");

   a_name_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.name_present |->
         rsp_data_ff.packet_status == ftpr_pkg::ST_START_OK ||
         rsp_data_ff.packet_status == ftpr_pkg::ST_END)
      else $error("name flag outside a good control packet");

   a_session_opens: assert property (@(posedge clock) disable iff (reset)
      fire && status_in == ftpr_pkg::ST_START_OK |=> session_ff)
      else $error("good start did not open the session");

endmodule

@@ sv/file_transfer_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// file_transfer_packet_receiver
// Receiver for data, start and end packets of a file-transfer link.
// ----------------------------------------------------------------------------
// Takes one packet byte per clock while the rsp side keeps up and returns
// exactly one result word per byte, so a sustained rate of one word per cycle.
// The edge that accepts a word on the req side writes it into the two-entry
// queue behind the classifier; from there it passes through the parser into
// the result register, which drives the rsp side. The parser never stalls on
// its own; only a stalled rsp side holds it, and the queue then fills and
// drops req_ready. Payload bytes of a data packet that ends with status
// "data short" have already been streamed and must be thrown away downstream.
// Register writes are always taken (csr_ready is tied high); write them only
// while no words are in flight. There is no clearing pass after reset.
module file_transfer_packet_receiver #(
   parameter int SIZE_BYTES_MAX = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ftpr_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ftpr_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ftpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);

   ftpr_pkg::cfg_type  cfg;
   logic               push_valid, push_ready;
   ftpr_pkg::word_type push_word;
   logic               pop_valid, pop_ready;
   ftpr_pkg::word_type pop_word;

   ftpr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_word   (push_word)
   );

   ftpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   ftpr_back #(
      .SIZE_BYTES_MAX (SIZE_BYTES_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_word    (pop_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/file_transfer_packet_receiver_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_transfer_packet_receiver_checker
// Watches the req, rsp and csr channels of the packet receiver, predicts the
// result word for every accepted byte and compares it field by field.
// ----------------------------------------------------------------------------
module file_transfer_packet_receiver_checker #(
   parameter int SIZE_BYTES_MAX = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  ftpr_pkg::req_type                req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  ftpr_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ftpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata,
   output int                               pending,
   output int                               mismatches
);
   import ftpr_pkg::*;

   typedef enum logic [3:0] {
      P_LEAD, P_SEQ, P_LEN_HI, P_LEN_LO, P_PAYLOAD, P_TAG, P_FLEN, P_VALUE, P_SKIP
   } phase_type;

   cfg_type     cfg;
   phase_type   phase;
   logic [1:0]  kind;
   logic [7:0]  ftag;
   logic [7:0]  fleft;
   logic [3:0]  taken;
   logic [63:0] accum;
   logic        named;
   logic        bad;
   logic [15:0] dlen;
   logic [16:0] pcount;
   logic [7:0]  seq;
   logic        in_session;
   logic [63:0] size_expected;
   logic [63:0] bytes_received;

   rsp_type expected_words[$];
   int      words_seen;

   initial begin
      pending    = 0;
      mismatches = 0;
      words_seen = 0;
   end

   // Parse one byte and return the result word it must produce
   function automatic rsp_type decode_byte(input req_type w);
      rsp_type    r;
      logic [7:0] b;
      logic       name_ok;
      b       = w.rx_byte;
      r       = '0;
      name_ok = 1'b0;
      case (phase)
         P_LEAD: begin
            kind   = KIND_OTHER;
            ftag   = '0;
            fleft  = '0;
            taken  = '0;
            accum  = '0;
            named  = 1'b0;
            bad    = 1'b0;
            dlen   = '0;
            pcount = '0;
            seq    = '0;
            // start wins over data, data wins over end
            if (b == cfg.start_code) begin
               kind  = KIND_START;
               phase = P_TAG;
            end else if (b == cfg.data_code) begin
               kind  = KIND_DATA;
               phase = in_session ? P_SEQ : P_SKIP;
            end else if (b == cfg.end_code) begin
               kind  = KIND_END;
               phase = P_TAG;
            end else begin
               phase = P_SKIP;
            end
         end
         P_SEQ: begin
            seq   = b;
            phase = P_LEN_HI;
         end
         P_LEN_HI: begin
            dlen  = {b, 8'h00};
            phase = P_LEN_LO;
         end
         P_LEN_LO: begin
            dlen[7:0] = b;
            phase     = P_PAYLOAD;
         end
         P_PAYLOAD: begin
            if (pcount < {1'b0, dlen}) begin
               r.out_kind = OUT_PAYLOAD;
               r.out_byte = b;
               pcount     = pcount + 17'd1;
            end
         end
         P_TAG: begin
            ftag  = b;
            phase = P_FLEN;
         end
         P_FLEN: begin
            fleft = b;
            if (ftag == cfg.size_tag) begin
               accum = '0;
               taken = '0;
            end else if (ftag == cfg.name_tag) begin
               named = 1'b1;
            end
            phase = (b == 8'd0) ? P_TAG : P_VALUE;
         end
         P_VALUE: begin
            if (ftag == cfg.size_tag) begin
               // keep only the leading size bytes
               if (taken < 4'(SIZE_BYTES_MAX)) begin
                  accum = {accum[55:0], b};
                  taken = taken + 4'd1;
               end
            end else if (ftag == cfg.name_tag) begin
               r.out_kind = OUT_NAME;
               r.out_byte = b;
            end
            fleft = fleft - 8'd1;
            if (fleft == 8'd0) phase = P_TAG;
         end
         default: phase = P_SKIP;
      endcase

      if (w.last_byte) begin
         if (kind == KIND_OTHER) begin
            r.packet_status = ST_UNKNOWN;
         end else if (kind == KIND_DATA) begin
            if (phase == P_SKIP) begin
               r.packet_status = ST_NO_SESSION;
            end else if (phase == P_PAYLOAD && pcount >= {1'b0, dlen}) begin
               bytes_received  = bytes_received + {48'd0, dlen};
               r.packet_status = ST_DATA_OK;
            end else begin
               r.packet_status = ST_DATA_SHORT;
            end
         end else begin
            // a value cut short spoils the whole control packet
            bad     = (phase == P_VALUE);
            name_ok = !bad && named;
            if (kind == KIND_START) begin
               if (name_ok) begin
                  in_session      = 1'b1;
                  size_expected   = accum;
                  bytes_received  = '0;
                  r.packet_status = ST_START_OK;
               end else begin
                  r.packet_status = ST_START_BAD;
               end
            end else begin
               in_session      = 1'b0;
               r.packet_status = ST_END;
            end
         end
         phase = P_LEAD;
      end

      r.seq_number     = seq;
      r.payload_length = dlen;
      r.file_size      = ((kind == KIND_START || kind == KIND_END) && !bad) ? accum : '0;
      r.name_present   = name_ok;
      r.expected_total = size_expected;
      r.received_total = bytes_received;
      r.session_open   = in_session;
      return r;
   endfunction

   task automatic flag_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: word %0d %0s expected %0h got %0h", $realtime, words_seen,
                  what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         cfg            = CFG_RESET;
         phase          = P_LEAD;
         kind           = KIND_DATA;
         ftag           = '0;
         fleft          = '0;
         taken          = '0;
         accum          = '0;
         named          = 1'b0;
         bad            = 1'b0;
         dlen           = '0;
         pcount         = '0;
         seq            = '0;
         in_session     = 1'b0;
         size_expected  = '0;
         bytes_received = '0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DATA_CODE:  cfg.data_code  = csr_wdata;
               CSR_START_CODE: cfg.start_code = csr_wdata;
               CSR_END_CODE:   cfg.end_code   = csr_wdata;
               CSR_SIZE_TAG:   cfg.size_tag   = csr_wdata;
               CSR_NAME_TAG:   cfg.name_tag   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result word %0h", $realtime, got);
            end else begin
               want = expected_words.pop_front();
               if (got.out_kind !== want.out_kind)
                  flag_field("out_kind", 64'(want.out_kind), 64'(got.out_kind));
               if (got.out_byte !== want.out_byte)
                  flag_field("out_byte", 64'(want.out_byte), 64'(got.out_byte));
               if (got.packet_status !== want.packet_status)
                  flag_field("packet_status", 64'(want.packet_status),
                             64'(got.packet_status));
               if (got.seq_number !== want.seq_number)
                  flag_field("seq_number", 64'(want.seq_number), 64'(got.seq_number));
               if (got.payload_length !== want.payload_length)
                  flag_field("payload_length", 64'(want.payload_length),
                             64'(got.payload_length));
               if (got.file_size !== want.file_size)
                  flag_field("file_size", want.file_size, got.file_size);
               if (got.name_present !== want.name_present)
                  flag_field("name_present", 64'(want.name_present),
                             64'(got.name_present));
               if (got.expected_total !== want.expected_total)
                  flag_field("expected_total", want.expected_total, got.expected_total);
               if (got.received_total !== want.received_total)
                  flag_field("received_total", want.received_total, got.received_total);
               if (got.session_open !== want.session_open)
                  flag_field("session_open", 64'(want.session_open),
                             64'(got.session_open));
            end
            words_seen++;
         end
         if (req_valid && req_ready)
            expected_words.push_back(decode_byte(req_payload));
      end
      pending = expected_words.size();
   end

endmodule

@@ tb/file_transfer_packet_receiver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_transfer_packet_receiver_tb
// Drives data, start, end, unknown and garbage packets into the receiver
// under several register settings, with random gaps on both channels, and
// takes the verdict from the checker running beside the block.
// ----------------------------------------------------------------------------
module file_transfer_packet_receiver_tb;
   import ftpr_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int PHASE_ITEMS  = 300;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [7:0]             csr_wdata   = '0;

   int         pending;
   int         mismatches;
   int         items       = 0;
   int         idle_cycles = 0;
   bit         calm        = 1'b0;
   cfg_type    cur_cfg     = CFG_RESET;
   logic [7:0] pkt[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   file_transfer_packet_receiver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   file_transfer_packet_receiver_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pending     (pending),
      .mismatches  (mismatches)
   );

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [7:0] b, input logic last);
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      if (calm || roll < 65) gap = 0;
      else if (roll < 95)    gap = $urandom_range(1, 3);
      else                   gap = $urandom_range(8, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{rx_byte: b, last_byte: last};
      do @(posedge clock); while (!req_ready);
      items++;
      @(negedge clock);
   endtask

   task automatic send_packet();
      calm = ($urandom_range(0, 3) == 0);
      foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
   endtask

   // Hold the sender until every result word is back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_regs(input cfg_type c);
      logic [CSR_INDEX_W-1:0] idx[5];
      logic [7:0]             val[5];
      idx = '{CSR_DATA_CODE, CSR_START_CODE, CSR_END_CODE, CSR_SIZE_TAG, CSR_NAME_TAG};
      val = '{c.data_code, c.start_code, c.end_code, c.size_tag, c.name_tag};
      settle();
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      cur_cfg = c;
   endtask

   task automatic build_data();
      int len;
      int count;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)      len = $urandom_range(0, 16);
      else if (roll < 95) len = $urandom_range(17, 64);
      else                len = $urandom_range(0, 65535);
      pkt = '{cur_cfg.data_code, 8'($urandom), 8'(len >> 8), 8'(len)};
      roll = $urandom_range(0, 99);
      if (len > 64)       count = $urandom_range(0, 24);
      else if (roll < 70) count = len;
      else if (roll < 82) count = len + $urandom_range(1, 4);
      else if (roll < 95) count = (len == 0) ? 0 : $urandom_range(0, len - 1);
      else begin
         // cut inside the header
         count = $urandom_range(1, 3);
         while (pkt.size() > count) void'(pkt.pop_back());
         count = 0;
      end
      repeat (count) pkt.push_back(8'($urandom));
   endtask

   task automatic build_control(input logic [7:0] code);
      int         fields;
      int         n;
      int         roll;
      logic [7:0] tag;
      pkt = '{code};
      fields = $urandom_range(0, 4);
      for (int f = 0; f < fields; f++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            tag = cur_cfg.size_tag;
            n   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
         end else if (roll < 80) begin
            tag = cur_cfg.name_tag;
            n   = $urandom_range(0, 6);
         end else begin
            tag = 8'($urandom);
            n   = $urandom_range(0, 4);
         end
         pkt.push_back(tag);
         pkt.push_back(8'(n));
         repeat (n) pkt.push_back(8'($urandom));
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         pkt.push_back(8'($urandom));
      end else if (roll < 20) begin
         // value ends before its declared length
         n = $urandom_range(2, 6);
         pkt.push_back($urandom_range(0, 1) ? cur_cfg.size_tag : cur_cfg.name_tag);
         pkt.push_back(8'(n));
         repeat ($urandom_range(0, n - 1)) pkt.push_back(8'($urandom));
      end
   endtask

   task automatic build_random_packet();
      int         roll;
      logic [7:0] lead;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         build_data();
      end else if (roll < 72) begin
         build_control(cur_cfg.start_code);
      end else if (roll < 80) begin
         build_control(cur_cfg.end_code);
      end else if (roll < 90) begin
         do lead = 8'($urandom);
         while (lead == cur_cfg.data_code || lead == cur_cfg.start_code ||
                lead == cur_cfg.end_code);
         pkt = '{lead};
         repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom));
      end else begin
         pkt = {};
         repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
      end
   endtask

   // Result side: random stalls, mostly short, with long fully ready stretches
   initial begin
      int roll;
      while (reset) @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         roll = $urandom_range(0, 99);
         repeat (roll < 10 ? $urandom_range(50, 200) : $urandom_range(1, 12))
            @(negedge clock);
         roll = $urandom_range(0, 99);
         rsp_ready <= 1'b0;
         if (roll < 60)      repeat ($urandom_range(1, 2)) @(negedge clock);
         else if (roll < 92) repeat ($urandom_range(3, 6)) @(negedge clock);
         else                repeat ($urandom_range(10, 40)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      cfg_type c;
      int      phase_start;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // no session yet: data refused, end still reported
      pkt = '{8'h01};                                         send_packet();
      pkt = '{8'h03};                                         send_packet();
      // start with a size but no name
      pkt = '{8'h02, 8'h00, 8'h01, 8'hFF};                    send_packet();
      // empty name, two-byte size, lone type byte at the end
      pkt = '{8'h02, 8'h01, 8'h00, 8'h00, 8'h02, 8'h12, 8'h34, 8'h07};
      send_packet();
      // header cut inside the length, zero length, short payload
      pkt = '{8'h01, 8'h05, 8'h00};                           send_packet();
      pkt = '{8'h01, 8'hFF, 8'h00, 8'h00};                    send_packet();
      pkt = '{8'h01, 8'h80, 8'h00, 8'h03, 8'h55};             send_packet();
      pkt = '{8'hC3};                                         send_packet();

      for (int ph = 0; ph < 6; ph++) begin
         c = CFG_RESET;
         case (ph)
            1: c = '{data_code: 8'h00, start_code: 8'hFF, end_code: 8'h80,
                     size_tag: 8'hFF, name_tag: 8'h00};
            2, 4: begin
               c.data_code = 8'($urandom);
               do c.start_code = 8'($urandom); while (c.start_code == c.data_code);
               do c.end_code = 8'($urandom);
               while (c.end_code == c.data_code || c.end_code == c.start_code);
               c.size_tag = 8'($urandom);
               // equal tags make every name field a size field
               c.name_tag = (ph == 2) ? c.size_tag : 8'($urandom);
            end
            3: begin
               // end code shadowed by the data code
               c.data_code = 8'($urandom);
               do c.start_code = 8'($urandom); while (c.start_code == c.data_code);
               c.end_code = c.data_code;
               c.size_tag = 8'($urandom);
               c.name_tag = 8'($urandom);
            end
            default: ;
         endcase
         if (ph > 0) write_regs(c);
         phase_start = items;
         while (items - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 39) == 0) settle();
            build_random_packet();
            send_packet();
         end
      end

      settle();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/ftpr_pkg.sv
sv/ftpr_front.sv
sv/ftpr_queue.sv
sv/ftpr_back.sv
sv/file_transfer_packet_receiver.sv
tb/file_transfer_packet_receiver_checker.sv
tb/file_transfer_packet_receiver_tb.sv
